// ----- sv/lcdnw_pkg.sv -----
// Shared types, codes and microcode ROM for the 4-bit character LCD write sequencer.
// No dependencies; imported by lcdnw_cfg_regs and char_lcd_nibble_write_sequencer_unit.
package lcdnw_pkg;

    localparam int LINE_LENGTH = 40;
    localparam logic [5:0] COL_MAX = 6'(LINE_LENGTH - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 18;
    localparam int EXTRA_W    = 17;

    localparam logic [2:0] MODE_DATA   = 3'd0;
    localparam logic [2:0] MODE_CMD    = 3'd1;
    localparam logic [2:0] MODE_INIT   = 3'd2;
    localparam logic [2:0] MODE_CURSOR = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [2:0] CFG_PHASE      = 3'd0;
    localparam logic [2:0] CFG_CMD_EXTRA  = 3'd1;
    localparam logic [2:0] CFG_DATA_EXTRA = 3'd2;
    localparam logic [2:0] CFG_CLR_EXTRA  = 3'd3;
    localparam logic [2:0] CFG_POWER_UP   = 3'd4;
    localparam logic [2:0] CFG_FIRST_RST  = 3'd5;
    localparam logic [2:0] CFG_LATER_RST  = 3'd6;
    localparam logic [2:0] CFG_MODE_SW    = 3'd7;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_DDRAM_ROW0 = 8'h80;
    localparam logic [7:0] CMD_DDRAM_ROW1 = 8'hC0;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] column;
    } in_item_t;

    typedef struct packed {
        logic              register_select;
        logic              enable_level;
        logic [3:0]        data_nibble;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] phase_wait_us;
        logic [CFG_DATA_W-1:0] command_extra_us;
        logic [CFG_DATA_W-1:0] data_extra_us;
        logic [CFG_DATA_W-1:0] clear_extra_us;
        logic [CFG_DATA_W-1:0] power_up_wait_us;
        logic [CFG_DATA_W-1:0] first_reset_wait_us;
        logic [CFG_DATA_W-1:0] later_reset_wait_us;
        logic [CFG_DATA_W-1:0] mode_switch_wait_us;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        phase_wait_us:       16'd100,
        command_extra_us:    16'd2000,
        data_extra_us:       16'd100,
        clear_extra_us:      16'd2000,
        power_up_wait_us:    16'd20000,
        first_reset_wait_us: 16'd5000,
        later_reset_wait_us: 16'd150,
        mode_switch_wait_us: 16'd100
    };

    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HIGH,
        NIB_LOW
    } nib_src_t;

    typedef enum logic [2:0] {
        EXTRA_NONE,
        EXTRA_BYTE,
        EXTRA_FIRST,
        EXTRA_LATER,
        EXTRA_MODE,
        EXTRA_CLEAR
    } extra_t;

    typedef struct packed {
        nib_src_t   src;
        logic [3:0] nib;
        extra_t     extra;
        logic       single;
        logic       done;
    } ucode_t;

    localparam int UC_ADDR_W = 4;
    localparam logic [UC_ADDR_W-1:0] UC_BYTE  = 4'd0;
    localparam logic [UC_ADDR_W-1:0] UC_INIT  = 4'd2;
    localparam logic [UC_ADDR_W-1:0] UC_CLEAR = 4'd13;

    // One word per nibble (or per single pin state).
    function automatic ucode_t ucode_rom(input logic [UC_ADDR_W-1:0] addr);
        ucode_t w;
        w = '{src: NIB_CONST, nib: 4'h0, extra: EXTRA_NONE, single: 1'b0, done: 1'b1};
        case (addr)
            4'd0:  w = '{NIB_HIGH,  4'h0, EXTRA_NONE,  1'b0, 1'b0};
            4'd1:  w = '{NIB_LOW,   4'h0, EXTRA_BYTE,  1'b0, 1'b1};
            4'd2:  w = '{NIB_CONST, 4'h0, EXTRA_NONE,  1'b1, 1'b0};
            4'd3:  w = '{NIB_CONST, 4'h3, EXTRA_FIRST, 1'b0, 1'b0};
            4'd4:  w = '{NIB_CONST, 4'h3, EXTRA_LATER, 1'b0, 1'b0};
            4'd5:  w = '{NIB_CONST, 4'h3, EXTRA_LATER, 1'b0, 1'b0};
            4'd6:  w = '{NIB_CONST, 4'h2, EXTRA_MODE,  1'b0, 1'b0};
            4'd7:  w = '{NIB_CONST, 4'h2, EXTRA_NONE,  1'b0, 1'b0};
            4'd8:  w = '{NIB_CONST, 4'h8, EXTRA_BYTE,  1'b0, 1'b0};
            4'd9:  w = '{NIB_CONST, 4'h0, EXTRA_NONE,  1'b0, 1'b0};
            4'd10: w = '{NIB_CONST, 4'hC, EXTRA_BYTE,  1'b0, 1'b0};
            4'd11: w = '{NIB_CONST, 4'h0, EXTRA_NONE,  1'b0, 1'b0};
            4'd12: w = '{NIB_CONST, 4'h6, EXTRA_BYTE,  1'b0, 1'b0};
            4'd13: w = '{NIB_CONST, 4'h0, EXTRA_NONE,  1'b0, 1'b0};
            4'd14: w = '{NIB_CONST, 4'h1, EXTRA_CLEAR, 1'b0, 1'b1};
            default: w = '{NIB_CONST, 4'h0, EXTRA_NONE, 1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/lcdnw_cfg_regs.sv -----
// Timing register file of the LCD write sequencer, written through a plain write port.
// Depends on lcdnw_pkg.
module lcdnw_cfg_regs
    import lcdnw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_PHASE:      cfg_next.phase_wait_us       = cfg_wdata;
                CFG_CMD_EXTRA:  cfg_next.command_extra_us    = cfg_wdata;
                CFG_DATA_EXTRA: cfg_next.data_extra_us       = cfg_wdata;
                CFG_CLR_EXTRA:  cfg_next.clear_extra_us      = cfg_wdata;
                CFG_POWER_UP:   cfg_next.power_up_wait_us    = cfg_wdata;
                CFG_FIRST_RST:  cfg_next.first_reset_wait_us = cfg_wdata;
                CFG_LATER_RST:  cfg_next.later_reset_wait_us = cfg_wdata;
                CFG_MODE_SW:    cfg_next.mode_switch_wait_us = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/char_lcd_nibble_write_sequencer_unit.sv -----
// Top level of the 4-bit character LCD write sequencer: microcoded pin-state generator.
// Depends on lcdnw_pkg and lcdnw_cfg_regs.
//
// Usage: one request item enters on s_valid/s_ready (s_item: mode, byte_value, row,
// column); it leaves as a run of pin-state items on m_valid/m_ready (m_item: RS, E,
// D4..D7, hold time, last flag). Data, command, set-cursor and clear requests give
// 6 pin states, init gives 37, modes 5 to 7 give none.
// A step counter walks a microcode ROM (one word per nibble) with a phase counter
// over the three pin states of a nibble; one pin state is produced per cycle unless the receiver stalls.
// The request is first registered (busy flag, step counter, byte), then each pin state
// is registered in the output register; a request occupies the block until its last
// pin state is produced, and s_ready stays low while a request is running.
// A stalled receiver holds the output register and freezes the step counter;
// the next request can be taken while the final pin state still waits.
// Reset clears the pending request and the output valid flag and loads the
// timing registers with their defaults. Write timing registers only when idle.
module char_lcd_nibble_write_sequencer_unit
    import lcdnw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    cfg_t cfg;

    lcdnw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic                 busy_reg, busy_next;
    logic [UC_ADDR_W-1:0] pc_reg, pc_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 rs_reg, rs_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    ucode_t              uc;
    logic [3:0]          nib;
    logic [EXTRA_W-1:0]  extra;
    logic [HOLD_W-1:0]   hold;
    logic                step_last;
    logic                advance;
    logic                accept;
    logic [5:0]          col_clamped;
    out_item_t           cur_item;

    assign uc          = ucode_rom(pc_reg);
    assign step_last   = uc.single || (phase_reg == 2'd2);
    assign advance     = busy_reg && (!m_valid_reg || m_ready);
    assign accept      = s_valid && s_ready;
    assign col_clamped = (s_item.column > COL_MAX) ? COL_MAX : s_item.column;

    always_comb begin
        case (uc.src)
            NIB_HIGH: nib = byte_reg[7:4];
            NIB_LOW:  nib = byte_reg[3:0];
            default:  nib = uc.nib;
        endcase

        case (uc.extra)
            EXTRA_BYTE:  extra = rs_reg ? EXTRA_W'(cfg.data_extra_us)
                                        : EXTRA_W'(cfg.command_extra_us);
            EXTRA_FIRST: extra = EXTRA_W'(cfg.first_reset_wait_us);
            EXTRA_LATER: extra = EXTRA_W'(cfg.later_reset_wait_us);
            EXTRA_MODE:  extra = EXTRA_W'(cfg.mode_switch_wait_us);
            EXTRA_CLEAR: extra = EXTRA_W'(cfg.command_extra_us)
                               + EXTRA_W'(cfg.clear_extra_us);
            default:     extra = '0;
        endcase

        if (uc.single) begin
            hold = HOLD_W'(cfg.power_up_wait_us);
        end else if (phase_reg == 2'd2) begin
            hold = HOLD_W'(cfg.phase_wait_us) + HOLD_W'(extra);
        end else begin
            hold = HOLD_W'(cfg.phase_wait_us);
        end

        cur_item.register_select = uc.single ? 1'b0 : rs_reg;
        cur_item.enable_level    = !uc.single && (phase_reg == 2'd1);
        cur_item.data_nibble     = uc.single ? 4'h0 : nib;
        cur_item.hold_us         = hold;
        cur_item.last            = uc.done && step_last;
    end

    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        phase_next   = phase_reg;
        rs_next      = rs_reg;
        byte_next    = byte_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (advance) begin
            m_valid_next = 1'b1;
            m_item_next  = cur_item;
            if (step_last) begin
                phase_next = 2'd0;
                pc_next    = pc_reg + 1'b1;
                if (uc.done) begin
                    busy_next = 1'b0;
                end
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            phase_next = 2'd0;
            rs_next    = (s_item.mode == MODE_DATA);
            byte_next  = s_item.byte_value;
            case (s_item.mode)
                MODE_DATA, MODE_CMD: begin
                    busy_next = 1'b1;
                    pc_next   = UC_BYTE;
                end
                MODE_CURSOR: begin
                    busy_next = 1'b1;
                    pc_next   = UC_BYTE;
                    byte_next = (s_item.row ? CMD_DDRAM_ROW1 : CMD_DDRAM_ROW0)
                              + {2'b00, col_clamped};
                end
                MODE_INIT: begin
                    busy_next = 1'b1;
                    pc_next   = UC_INIT;
                end
                MODE_CLEAR: begin
                    busy_next = 1'b1;
                    pc_next   = UC_CLEAR;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            phase_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
        rs_reg     <= rs_next;
        byte_reg   <= byte_next;
        m_item_reg <= m_item_next;
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_unknown_mode_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_item.mode != MODE_DATA) && (s_item.mode != MODE_CMD)
         && (s_item.mode != MODE_INIT) && (s_item.mode != MODE_CURSOR)
         && (s_item.mode != MODE_CLEAR)) |=> !busy_reg)
        else $error("unknown mode started a sequence");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cur_item.last) |=> !busy_reg)
        else $error("sequence kept running after its last pin state");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (phase_reg != 2'd3))
        else $error("phase counter out of range");

    a_strobe_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.enable_level) |-> !m_item.last)
        else $error("request ended with the enable strobe high");

endmodule
